// ===== hw/rtl/tile_background_scanline_renderer_core_defines.svh =====
// Assertion macros for the tile background renderer.
// Used by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef TILE_BACKGROUND_SCANLINE_RENDERER_CORE_DEFINES_SVH
`define TILE_BACKGROUND_SCANLINE_RENDERER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TBSR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbsr check failed");
`define TBSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbsr check failed");
`else
`define TBSR_ASSERT_IMP(label, ante, cons)
`define TBSR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/tbsr_pkg.sv =====
// Shared types, codes and constants of the tile background renderer.
// No dependencies.
`timescale 1ns / 1ps
package tbsr_pkg;

    localparam int VRAM_BYTES            = 8192;
    localparam int VRAM_AW               = 13;
    localparam int LINE_PIXELS_DEF       = 160;
    localparam int VISIBLE_LINES_DEF     = 144;
    localparam int PIXELS_PER_RESULT_DEF = 4;

    localparam logic [7:0] LAST_LINE   = 8'd153;
    localparam logic [8:0] CYCLE_MAX   = 9'h1FF;
    localparam logic [1:0] MAP_BASE_HI = 2'b11;

    localparam logic [7:0] OAM_RST      = 8'd20;
    localparam logic [7:0] TRANSFER_RST = 8'd43;
    localparam logic [7:0] HBLANK_RST   = 8'd51;
    localparam logic [7:0] LINE_RST     = 8'd114;

    localparam logic [7:0] CFG_OAM      = 8'd0;
    localparam logic [7:0] CFG_TRANSFER = 8'd1;
    localparam logic [7:0] CFG_HBLANK   = 8'd2;
    localparam logic [7:0] CFG_LINE     = 8'd3;

    localparam logic [12:0] REG_CONTROL = 13'd0;
    localparam logic [12:0] REG_STATUS  = 13'd1;
    localparam logic [12:0] REG_SCROLLY = 13'd2;
    localparam logic [12:0] REG_SCROLLX = 13'd3;
    localparam logic [12:0] REG_LINE    = 13'd4;
    localparam logic [12:0] REG_PALETTE = 13'd5;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_VRAM  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    typedef struct packed {
        logic            map_sel;
        logic            tile_sel;
        logic [7:0]      scroll_x;
        logic [7:0]      scroll_y;
        logic [7:0]      line;
        logic [3:0][7:0] shades;
    } rnd_cfg_t;

    typedef struct packed {
        logic [3:0][7:0] shades;
        logic [7:0]      column;
        logic            last;
    } rnd_grp_t;

    function automatic logic [7:0] shade_code(input logic [1:0] c);
        logic [7:0] r;
        unique case (c)
            2'd0: r = 8'd255;
            2'd1: r = 8'd192;
            2'd2: r = 8'd96;
            2'd3: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/tbsr_ram.sv =====
// Generic synchronous RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module tbsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/tbsr_render.sv =====
// Line render sequencer: fetches map entries and tile rows from video memory and emits shaded pixel groups.
// Depends on tbsr_pkg; reads through the tbsr_ram read port.
`timescale 1ns / 1ps
module tbsr_render #(
    parameter int LINE_PIXELS       = tbsr_pkg::LINE_PIXELS_DEF,
    parameter int PIXELS_PER_RESULT = tbsr_pkg::PIXELS_PER_RESULT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  tbsr_pkg::rnd_cfg_t           cfg,
    output logic [tbsr_pkg::VRAM_AW-1:0] rd_addr,
    input  logic [7:0]                   rd_data,
    output logic                         grp_valid,
    input  logic                         grp_ready,
    output tbsr_pkg::rnd_grp_t           grp
);
    import tbsr_pkg::*;

    localparam int XW = $clog2(LINE_PIXELS);
    localparam int PW = (PIXELS_PER_RESULT > 1) ? $clog2(PIXELS_PER_RESULT) : 1;

    typedef enum logic [6:0] {
        R_IDLE = 7'b0000001,
        R_MAP  = 7'b0000010,
        R_TILE = 7'b0000100,
        R_LO   = 7'b0001000,
        R_HI   = 7'b0010000,
        R_PIX  = 7'b0100000,
        R_EMIT = 7'b1000000
    } rstate_t;

    rstate_t         state_reg, state_next;
    logic [2:0]      tx_reg, tx_next;
    logic [4:0]      col_reg, col_next;
    logic [8:0]      tile_reg, tile_next;
    logic [7:0]      lo_reg, lo_next;
    logic [7:0]      hi_reg, hi_next;
    logic [XW-1:0]   x_reg, x_next;
    logic [PW-1:0]   p_reg, p_next;
    logic [3:0][7:0] sh_reg, sh_next;
    logic [7:0]      column_reg, column_next;
    logic            fetch_reg, fetch_next;
    logic            last_reg, last_next;

    logic [7:0] y;
    logic [2:0] ty;
    logic [1:0] color;
    logic       wrap;
    logic       done;

    assign y  = cfg.line + cfg.scroll_y;
    assign ty = y[2:0];

    always_comb
    begin
        state_next  = state_reg;
        tx_next     = tx_reg;
        col_next    = col_reg;
        tile_next   = tile_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        x_next      = x_reg;
        p_next      = p_reg;
        sh_next     = sh_reg;
        column_next = column_reg;
        fetch_next  = fetch_reg;
        last_next   = last_reg;
        rd_addr     = {MAP_BASE_HI, cfg.map_sel, y[7:3], col_reg};
        color       = {hi_reg[3'd7 - tx_reg], lo_reg[3'd7 - tx_reg]};
        wrap        = (tx_reg == 3'd7);
        done        = (p_reg == PW'(PIXELS_PER_RESULT - 1)) || (x_reg == XW'(LINE_PIXELS - 1));
        grp_valid   = (state_reg == R_EMIT);
        unique case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    col_next    = cfg.scroll_x[7:3];
                    tx_next     = cfg.scroll_x[2:0];
                    x_next      = '0;
                    p_next      = '0;
                    sh_next     = '0;
                    column_next = '0;
                    state_next  = R_MAP;
                end
            end
            R_MAP:
            begin
                state_next = R_TILE;
            end
            R_TILE:
            begin
                tile_next  = (!cfg.tile_sel && !rd_data[7]) ? {1'b1, rd_data} : {1'b0, rd_data};
                rd_addr    = {tile_next, ty, 1'b0};
                state_next = R_LO;
            end
            R_LO:
            begin
                lo_next    = rd_data;
                rd_addr    = {tile_reg, ty, 1'b1};
                state_next = R_HI;
            end
            R_HI:
            begin
                hi_next    = rd_data;
                state_next = R_PIX;
            end
            R_PIX:
            begin
                if (32'(p_reg) < 4)
                begin
                    sh_next[2'(p_reg)] = cfg.shades[color];
                end
                x_next  = x_reg + 1'b1;
                p_next  = p_reg + 1'b1;
                tx_next = tx_reg + 1'b1;
                if (wrap)
                begin
                    col_next = col_reg + 1'b1;
                end
                if (done)
                begin
                    fetch_next = wrap;
                    last_next  = (x_reg == XW'(LINE_PIXELS - 1));
                    state_next = R_EMIT;
                end
                else if (wrap)
                begin
                    state_next = R_MAP;
                end
            end
            R_EMIT:
            begin
                if (grp_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = R_IDLE;
                    end
                    else
                    begin
                        sh_next     = '0;
                        p_next      = '0;
                        column_next = column_reg + 8'(PIXELS_PER_RESULT);
                        state_next  = fetch_reg ? R_MAP : R_PIX;
                    end
                end
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    assign grp.shades = sh_reg;
    assign grp.column = column_reg;
    assign grp.last   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg     <= tx_next;
        col_reg    <= col_next;
        tile_reg   <= tile_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        x_reg      <= x_next;
        p_reg      <= p_next;
        sh_reg     <= sh_next;
        column_reg <= column_next;
        fetch_reg  <= fetch_next;
        last_reg   <= last_next;
    end

endmodule

// ===== hw/rtl/tile_background_scanline_renderer_core.sv =====
// Results: a read or tick result is registered in the cycle after acceptance; writes give no result.
// Throughput: one item per cycle while the result register drains; a tick that ends
// transfer runs the render sequencer (per tile a map read, tile number, low and high row
// bytes, then a step per pixel and one per group, stalling on the result), accepting nothing meanwhile.
// Reset: state and configuration registers take their reset values, then a clearing pass writes
// zero through all 8192 bytes of video memory before the first item is taken.
`timescale 1ns / 1ps
`include "tile_background_scanline_renderer_core_defines.svh"
module tile_background_scanline_renderer_core #(
    parameter int LINE_PIXELS       = tbsr_pkg::LINE_PIXELS_DEF,
    parameter int VISIBLE_LINES     = tbsr_pkg::VISIBLE_LINES_DEF,
    parameter int PIXELS_PER_RESULT = tbsr_pkg::PIXELS_PER_RESULT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  kind,
    input  logic [12:0] address,
    input  logic [7:0]  data,
    input  logic [5:0]  cycles,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  read_data,
    output logic [7:0]  shade_0,
    output logic [7:0]  shade_1,
    output logic [7:0]  shade_2,
    output logic [7:0]  shade_3,
    output logic [7:0]  current_line,
    output logic [7:0]  first_column,
    output logic        last,
    output logic        frame_start,
    output logic [1:0]  mode,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import tbsr_pkg::*;

    typedef enum logic [2:0] {
        T_CLEAR  = 3'b001,
        T_IDLE   = 3'b010,
        T_RENDER = 3'b100
    } tstate_t;

    tstate_t              state_reg, state_next;
    logic [VRAM_AW-1:0]   clear_addr_reg;
    logic [7:0]           oam_cycles_reg, transfer_cycles_reg, hblank_cycles_reg;
    logic [7:0]           line_cycles_reg;
    mode_t                mode_reg, mode_next;
    logic [8:0]           cycle_count_reg, cycle_count_next;
    logic [7:0]           line_count_reg, line_count_next;
    logic [7:0]           scroll_x_reg, scroll_y_reg, status_reg;
    logic [3:0]           control_reg;
    logic [3:0][7:0]      shade_reg;

    logic                 result_valid_reg;
    logic [7:0]           read_data_reg, current_line_reg, first_column_reg;
    logic [3:0][7:0]      shades_reg;
    logic                 last_reg, frame_start_reg;
    logic [1:0]           mode_out_reg;

    logic                 accept, slot_free, out_load, clearing;
    logic                 render_start, fs;
    logic [9:0]           sum;
    logic [8:0]           sat;
    logic [7:0]           line_inc, rd_value;
    logic                 ram_we;
    logic [VRAM_AW-1:0]   ram_waddr, ram_raddr;
    logic [7:0]           ram_wdata, ram_rdata;
    rnd_cfg_t             rcfg;
    rnd_grp_t             grp;
    logic                 grp_valid, grp_ready;

    assign clearing   = (state_reg == T_CLEAR);
    assign slot_free  = !result_valid_reg || result_ready;
    assign item_ready = (state_reg == T_IDLE) && slot_free;
    assign accept     = item_valid && item_ready;
    assign cfg_ready  = 1'b1;
    assign grp_ready  = (state_reg == T_RENDER) && slot_free;

    assign ram_we    = clearing || (accept && kind == KIND_VRAM);
    assign ram_waddr = clearing ? clear_addr_reg : address;
    assign ram_wdata = clearing ? 8'd0 : data;

    tbsr_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_BYTES)
    ) u_vram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rcfg.map_sel  = control_reg[1];
    assign rcfg.tile_sel = control_reg[2];
    assign rcfg.scroll_x = scroll_x_reg;
    assign rcfg.scroll_y = scroll_y_reg;
    assign rcfg.line     = line_count_reg;
    assign rcfg.shades   = shade_reg;

    tbsr_render #(
        .LINE_PIXELS       (LINE_PIXELS),
        .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
    ) u_render (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (render_start),
        .cfg       (rcfg),
        .rd_addr   (ram_raddr),
        .rd_data   (ram_rdata),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp)
    );

    always_comb
    begin
        sum              = {1'b0, cycle_count_reg} + 10'(cycles);
        sat              = sum[9] ? CYCLE_MAX : sum[8:0];
        line_inc         = line_count_reg + 8'd1;
        mode_next        = mode_reg;
        cycle_count_next = sat;
        line_count_next  = line_count_reg;
        fs               = 1'b0;
        render_start     = 1'b0;
        unique case (mode_reg)
            MODE_HBLANK:
            begin
                if (sat >= {1'b0, hblank_cycles_reg})
                begin
                    cycle_count_next = '0;
                    line_count_next  = line_inc;
                    if (line_inc == 8'(VISIBLE_LINES))
                    begin
                        mode_next = MODE_VBLANK;
                        fs        = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_OAM;
                    end
                end
            end
            MODE_VBLANK:
            begin
                if (sat >= {1'b0, line_cycles_reg})
                begin
                    cycle_count_next = '0;
                    if (line_inc > LAST_LINE)
                    begin
                        mode_next       = MODE_OAM;
                        line_count_next = '0;
                    end
                    else
                    begin
                        line_count_next = line_inc;
                    end
                end
            end
            MODE_OAM:
            begin
                if (sat >= {1'b0, oam_cycles_reg})
                begin
                    cycle_count_next = '0;
                    mode_next        = MODE_XFER;
                end
            end
            MODE_XFER:
            begin
                if (sat >= {1'b0, transfer_cycles_reg})
                begin
                    cycle_count_next = '0;
                    mode_next        = MODE_HBLANK;
                    render_start     = accept && (kind == KIND_TICK);
                end
            end
        endcase
    end

    always_comb
    begin
        unique case (address)
            REG_CONTROL: rd_value = {control_reg[3], 2'b00, control_reg[2], control_reg[1],
                                     2'b00, control_reg[0]};
            REG_STATUS:  rd_value = status_reg;
            REG_SCROLLY: rd_value = scroll_y_reg;
            REG_SCROLLX: rd_value = scroll_x_reg;
            REG_LINE:    rd_value = line_count_reg;
            default:     rd_value = 8'd0;
        endcase
    end

    assign out_load = (accept && kind == KIND_READ) ||
                      (accept && kind == KIND_TICK && !render_start) ||
                      (grp_valid && grp_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_CLEAR:
            begin
                if (clear_addr_reg == VRAM_AW'(VRAM_BYTES - 1))
                begin
                    state_next = T_IDLE;
                end
            end
            T_IDLE:
            begin
                if (render_start)
                begin
                    state_next = T_RENDER;
                end
            end
            T_RENDER:
            begin
                if (grp_valid && grp_ready && grp.last)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= T_CLEAR;
            clear_addr_reg      <= '0;
            oam_cycles_reg      <= OAM_RST;
            transfer_cycles_reg <= TRANSFER_RST;
            hblank_cycles_reg   <= HBLANK_RST;
            line_cycles_reg     <= LINE_RST;
            mode_reg            <= MODE_OAM;
            cycle_count_reg     <= '0;
            line_count_reg      <= '0;
            scroll_x_reg        <= '0;
            scroll_y_reg        <= '0;
            control_reg         <= '0;
            status_reg          <= '0;
            shade_reg           <= {4{8'd255}};
            result_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_OAM:      oam_cycles_reg      <= cfg_data;
                    CFG_TRANSFER: transfer_cycles_reg <= cfg_data;
                    CFG_HBLANK:   hblank_cycles_reg   <= cfg_data;
                    CFG_LINE:     line_cycles_reg     <= cfg_data;
                    default:      ;
                endcase
            end
            if (accept && kind == KIND_TICK)
            begin
                mode_reg        <= mode_next;
                cycle_count_reg <= cycle_count_next;
                line_count_reg  <= line_count_next;
            end
            if (accept && kind == KIND_WRITE)
            begin
                unique case (address)
                    REG_CONTROL: control_reg  <= {data[7], data[4], data[3], data[0]};
                    REG_STATUS:  status_reg   <= data;
                    REG_SCROLLY: scroll_y_reg <= data;
                    REG_SCROLLX: scroll_x_reg <= data;
                    REG_PALETTE:
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            shade_reg[i] <= shade_code(data[2*i +: 2]);
                        end
                    end
                    default: ;
                endcase
            end
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (grp_valid && grp_ready)
            begin
                read_data_reg    <= 8'd0;
                shades_reg       <= grp.shades;
                current_line_reg <= line_count_reg;
                first_column_reg <= grp.column;
                last_reg         <= grp.last;
                frame_start_reg  <= 1'b0;
                mode_out_reg     <= mode_reg;
            end
            else if (kind == KIND_READ)
            begin
                read_data_reg    <= rd_value;
                shades_reg       <= '0;
                current_line_reg <= line_count_reg;
                first_column_reg <= 8'd0;
                last_reg         <= 1'b1;
                frame_start_reg  <= 1'b0;
                mode_out_reg     <= mode_reg;
            end
            else
            begin
                read_data_reg    <= 8'd0;
                shades_reg       <= '0;
                current_line_reg <= line_count_next;
                first_column_reg <= 8'd0;
                last_reg         <= 1'b1;
                frame_start_reg  <= fs;
                mode_out_reg     <= mode_next;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign read_data    = read_data_reg;
    assign shade_0      = shades_reg[0];
    assign shade_1      = shades_reg[1];
    assign shade_2      = shades_reg[2];
    assign shade_3      = shades_reg[3];
    assign current_line = current_line_reg;
    assign first_column = first_column_reg;
    assign last         = last_reg;
    assign frame_start  = frame_start_reg;
    assign mode         = mode_out_reg;

    `TBSR_ASSERT_IMP(a_load_slot_free, out_load, slot_free)
    `TBSR_ASSERT_IMP(a_no_result_in_clear, clearing, !result_valid_reg)
    `TBSR_ASSERT_NEXT(a_last_group_idle, grp_valid && grp_ready && grp.last, state_reg == T_IDLE)
    `TBSR_ASSERT_IMP(a_vblank_lines, mode_reg == MODE_VBLANK, line_count_reg >= 8'(VISIBLE_LINES))
    `TBSR_ASSERT_IMP(a_group_only_in_render, grp_valid, state_reg == T_RENDER)

endmodule

// ===== dv/tbsr_line_checker.sv =====
// Checker for the tile background renderer: watches the item, result and register
// channels, predicts every result from its own copy of the block state and compares.
// Depends on tbsr_pkg for the kind, mode and register codes.
`timescale 1ns / 1ps
module tbsr_line_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [1:0]  kind,
    input  logic [12:0] address,
    input  logic [7:0]  data,
    input  logic [5:0]  cycles,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [7:0]  read_data,
    input  logic [7:0]  shade_0,
    input  logic [7:0]  shade_1,
    input  logic [7:0]  shade_2,
    input  logic [7:0]  shade_3,
    input  logic [7:0]  current_line,
    input  logic [7:0]  first_column,
    input  logic        last,
    input  logic        frame_start,
    input  logic [1:0]  mode,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          pending,
    output int          fails
);
    import tbsr_pkg::*;

    typedef struct packed {
        logic [7:0]      rd;
        logic [3:0][7:0] sh;
        logic [7:0]      line;
        logic [7:0]      col;
        logic            last;
        logic            fs;
        logic [1:0]      md;
    } video_result_t;

    localparam logic [7:0] GREY_LEVELS [4] = '{8'd255, 8'd192, 8'd96, 8'd0};

    video_result_t expected_results[$];

    logic [7:0] oam_thr      = OAM_RST;
    logic [7:0] transfer_thr = TRANSFER_RST;
    logic [7:0] hblank_thr   = HBLANK_RST;
    logic [7:0] vblank_thr   = LINE_RST;
    mode_t      cur_mode     = MODE_OAM;
    logic [8:0] cyc_acc      = '0;
    logic [7:0] line_no      = '0;
    logic [7:0] scx          = '0;
    logic [7:0] scy          = '0;
    logic [7:0] ctrl         = '0;
    logic [7:0] status       = '0;
    logic [7:0] grey [4]     = '{8'd255, 8'd255, 8'd255, 8'd255};
    logic [7:0] vram [VRAM_BYTES];

    initial
    begin
        pending = 0;
        fails   = 0;
        foreach (vram[i]) vram[i] = '0;
    end

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fails++;
    endtask

    function automatic int tile_of(input logic [7:0] entry);
        if (!ctrl[4] && entry < 8'd128)
            return int'(entry) + 256;
        return int'(entry);
    endfunction

    task automatic push_status(input logic [7:0] rd, input logic fs);
        video_result_t r;
        r = '0;
        r.rd = rd;
        r.line = line_no;
        r.last = 1'b1;
        r.fs = fs;
        r.md = cur_mode;
        expected_results.push_back(r);
    endtask

    task automatic predict_line();
        int base, y, row_off, col, tx, ty, tile, a, c, x;
        video_result_t r;
        base = ctrl[3] ? 'h1C00 : 'h1800;
        y = (int'(line_no) + int'(scy)) & 'hFF;
        row_off = (y >> 3) << 5;
        col = (int'(scx) >> 3) & 'h1F;
        tx = scx & 7;
        ty = y & 7;
        tile = tile_of(vram[base + row_off + col]);
        x = 0;
        for (int g = 0; g < 40; g++)
        begin
            r = '0;
            for (int p = 0; p < 4; p++)
            begin
                a = (tile * 16 + ty * 2) % VRAM_BYTES;
                c = ((vram[a] >> (7 - tx)) & 1) | (((vram[(a + 1) % VRAM_BYTES] >> (7 - tx)) & 1) << 1);
                r.sh[p] = grey[c & 3];
                tx++;
                if (tx == 8)
                begin
                    tx = 0;
                    col = (col + 1) & 'h1F;
                    tile = tile_of(vram[base + row_off + col]);
                end
            end
            r.line = line_no;
            r.col = 8'(g * 4);
            r.last = (g == 39);
            r.md = cur_mode;
            expected_results.push_back(r);
        end
    endtask

    task automatic predict_item(input kind_t k, input logic [12:0] a, input logic [7:0] d,
                                input logic [5:0] cyc);
        logic fs;
        logic [9:0] sum;
        logic [7:0] rd;
        fs = 1'b0;
        rd = '0;
        case (k)
            KIND_VRAM: vram[a] = d;
            KIND_WRITE:
                case (a)
                    REG_CONTROL: ctrl = d & 8'h99;
                    REG_STATUS:  status = d;
                    REG_SCROLLY: scy = d;
                    REG_SCROLLX: scx = d;
                    REG_PALETTE: for (int i = 0; i < 4; i++) grey[i] = GREY_LEVELS[d[2*i +: 2]];
                    default: ;
                endcase
            KIND_READ:
            begin
                case (a)
                    REG_CONTROL: rd = ctrl;
                    REG_STATUS:  rd = status;
                    REG_SCROLLY: rd = scy;
                    REG_SCROLLX: rd = scx;
                    REG_LINE:    rd = line_no;
                    default:     rd = '0;
                endcase
                push_status(rd, 1'b0);
            end
            default:
            begin
                sum = cyc_acc + cyc;
                cyc_acc = (sum > 10'd511) ? 9'd511 : sum[8:0];
                case (cur_mode)
                    MODE_HBLANK:
                        if (cyc_acc >= hblank_thr)
                        begin
                            cyc_acc = '0;
                            line_no++;
                            if (line_no == 8'(VISIBLE_LINES_DEF))
                            begin
                                cur_mode = MODE_VBLANK;
                                fs = 1'b1;
                            end
                            else
                                cur_mode = MODE_OAM;
                        end
                    MODE_VBLANK:
                        if (cyc_acc >= vblank_thr)
                        begin
                            cyc_acc = '0;
                            line_no++;
                            if (line_no > LAST_LINE)
                            begin
                                cur_mode = MODE_OAM;
                                line_no = '0;
                            end
                        end
                    MODE_OAM:
                        if (cyc_acc >= oam_thr)
                        begin
                            cyc_acc = '0;
                            cur_mode = MODE_XFER;
                        end
                    default:
                        if (cyc_acc >= transfer_thr)
                        begin
                            cyc_acc = '0;
                            cur_mode = MODE_HBLANK;
                            predict_line();
                            return;
                        end
                endcase
                push_status(8'd0, fs);
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        video_result_t got, exp_r;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                got = '{read_data, {shade_3, shade_2, shade_1, shade_0}, current_line,
                        first_column, last, frame_start, mode};
                if (expected_results.size() == 0)
                    report($sformatf("unexpected result %h", got));
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r)
                        report($sformatf("got %h want %h", got, exp_r));
                end
            end
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_OAM:      oam_thr = cfg_data;
                    CFG_TRANSFER: transfer_thr = cfg_data;
                    CFG_HBLANK:   hblank_thr = cfg_data;
                    CFG_LINE:     vblank_thr = cfg_data;
                    default: ;
                endcase
            if (item_valid && item_ready)
                predict_item(kind_t'(kind), address, data, cycles);
            pending = expected_results.size();
        end
    end

endmodule

// ===== dv/tb_tile_background_scanline_renderer_core.sv =====
// Top of the renderer testbench: clock, reset, bursty item stimulus, register writes
// and a stalling result receiver; verdict from the failure count of tbsr_line_checker.
// Depends on tbsr_pkg, tbsr_line_checker and tile_background_scanline_renderer_core.
`timescale 1ns / 1ps
module tb_tile_background_scanline_renderer_core;
    import tbsr_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [1:0]  kind = '0;
    logic [12:0] address = '0;
    logic [7:0]  data = '0;
    logic [5:0]  cycles = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [7:0]  read_data, shade_0, shade_1, shade_2, shade_3;
    logic [7:0]  current_line, first_column;
    logic        last, frame_start;
    logic [1:0]  mode;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    int          pending, fails;
    int          burst_left = 0;
    int          holds_asked = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    tile_background_scanline_renderer_core u_dut (.*);
    tbsr_line_checker u_checker (.*);

    // receiver: stall pattern is redrawn at random between runs; long hold-offs on request
    initial
    begin
        int served, pat, hold_left;
        served = 0;
        pat = 0;
        hold_left = 0;
        forever
        begin
            for (int n = 0; n < 64; n++)
            begin
                @(negedge clk);
                if (served != holds_asked)
                begin
                    served = holds_asked;
                    hold_left = 400;
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    result_ready = 1'b0;
                end
                else
                    case (pat)
                        0: result_ready = 1'b1;
                        1: result_ready = $urandom_range(1, 0);
                        2: result_ready = ($urandom_range(3, 0) == 0);
                        default: result_ready = (n % 16) < 10;
                    endcase
            end
            pat = $urandom_range(3, 0);
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_tile_background_scanline_renderer_core NOT OK");
        $finish;
    end

    task automatic send_item(input kind_t k, input logic [12:0] a, input logic [7:0] d,
                             input logic [5:0] cyc);
        if (burst_left == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(6, 0)) @(negedge clk);
            burst_left = $urandom_range(20, 1);
        end
        kind = k;
        address = a;
        data = d;
        cycles = cyc;
        item_valid = 1'b1;
        do @(posedge clk); while (!item_ready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic drain();
        item_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_timing(input logic [7:0] o, input logic [7:0] t,
                                input logic [7:0] h, input logic [7:0] l);
        logic [7:0] vals [4];
        vals = '{o, t, h, l};
        drain();
        for (int i = 0; i < 4; i++)
        begin
            cfg_index = 8'(i);
            cfg_data = vals[i];
            cfg_valid = 1'b1;
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    task automatic random_item();
        int r;
        logic [12:0] a;
        r = $urandom_range(99, 0);
        if (r < 40)
            send_item(KIND_TICK, 13'($urandom), 8'($urandom),
                      ($urandom_range(3, 0) == 0) ? 6'd63 : 6'($urandom));
        else if (r < 65)
        begin
            a = ($urandom_range(1, 0) == 1) ? 13'h1800 + 13'($urandom_range(2047, 0))
                                              : 13'($urandom);
            send_item(KIND_VRAM, a, 8'($urandom), 6'($urandom));
        end
        else if (r < 85)
        begin
            a = ($urandom_range(7, 0) == 0) ? 13'($urandom) : 13'($urandom_range(5, 0));
            send_item(KIND_WRITE, a, 8'($urandom), 6'($urandom));
        end
        else
        begin
            a = ($urandom_range(7, 0) == 0) ? 13'($urandom) : 13'($urandom_range(5, 0));
            send_item(KIND_READ, a, 8'($urandom), 6'($urandom));
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i <= 5; i++) send_item(KIND_READ, 13'(i), 8'h00, 6'd0);
        send_item(KIND_READ, 13'h1FFF, 8'hFF, 6'h3F);
        send_item(KIND_WRITE, REG_CONTROL, 8'hFF, 6'd0);
        send_item(KIND_READ, REG_CONTROL, 8'h00, 6'd0);
        send_item(KIND_WRITE, REG_STATUS, 8'hFF, 6'd0);
        send_item(KIND_WRITE, REG_SCROLLX, 8'hFF, 6'd0);
        send_item(KIND_WRITE, REG_SCROLLY, 8'hFF, 6'd0);
        send_item(KIND_WRITE, REG_LINE, 8'h55, 6'd0);
        send_item(KIND_WRITE, 13'h1FFF, 8'hAA, 6'd0);
        send_item(KIND_WRITE, REG_PALETTE, 8'hE4, 6'd0);
        send_item(KIND_VRAM, 13'h0000, 8'hFF, 6'd0);
        send_item(KIND_VRAM, 13'h1FFF, 8'hFF, 6'd0);
        send_item(KIND_VRAM, 13'h1C00, 8'h00, 6'd0);
        send_item(KIND_VRAM, 13'h1001, 8'h5A, 6'd0);
        send_item(KIND_READ, 13'h0006, 8'h00, 6'd0);
        send_item(KIND_TICK, 13'h0000, 8'h00, 6'd0);
        send_item(KIND_TICK, 13'h0000, 8'h00, 6'd63);
        send_item(KIND_TICK, 13'h0000, 8'h00, 6'd63);
        send_item(KIND_WRITE, REG_CONTROL, 8'h00, 6'd0);
        send_item(KIND_WRITE, REG_PALETTE, 8'h1B, 6'd0);
        send_item(KIND_TICK, 13'h1FFF, 8'hFF, 6'd63);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_timing(8'd1, 8'd1, 8'd1, 8'd1);
                1: write_timing(8'd255, 8'd255, 8'd255, 8'd255);
                2: write_timing(8'd20, 8'd43, 8'd51, 8'd114);
                default: write_timing(8'($urandom_range(255, 1)), 8'($urandom_range(64, 1)),
                                      8'($urandom_range(64, 1)), 8'($urandom_range(255, 1)));
            endcase
            for (int n = 0; n < 30; n++)
            begin
                if (ph == 0 && n == 5) holds_asked++;
                random_item();
            end
        end

        // run ticks at the shortest nonzero thresholds, reading the line register now and then
        write_timing(8'd1, 8'd1, 8'd1, 8'd1);
        for (int n = 0; n < 30; n++)
        begin
            if (n == 10) holds_asked++;
            if (n % 10 == 0)
                send_item(KIND_READ, REG_LINE, 8'h00, 6'd0);
            send_item(KIND_TICK, 13'($urandom), 8'($urandom), 6'($urandom_range(63, 1)));
        end

        drain();
        repeat (50) @(negedge clk);
        if (fails == 0)
            $display("tb_tile_background_scanline_renderer_core OK");
        else
            $display("tb_tile_background_scanline_renderer_core NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tbsr_pkg.sv
hw/rtl/tbsr_ram.sv
hw/rtl/tbsr_render.sv
hw/rtl/tile_background_scanline_renderer_core.sv
dv/tbsr_line_checker.sv
dv/tb_tile_background_scanline_renderer_core.sv
